>>> src/bac_pkg.sv
package bac_pkg;

  // Fixed field widths
  localparam int unsigned LitW    = 32;
  localparam int unsigned NsW     = 13;
  localparam int unsigned NsubW   = 7;
  localparam int unsigned AuxW    = 31;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 31;

  // Limits
  localparam int unsigned MaxGroup      = 32;
  localparam int unsigned MaxStates     = 4096;
  localparam int unsigned MaxSubsetBits = 6;
  localparam int unsigned MaxSubsets    = 1 << MaxSubsetBits;

  // Divider operand width: holds num_states + num_subsets - 1
  localparam int unsigned DivW  = NsW + 1;
  localparam int unsigned BitsW = $clog2(MaxSubsetBits + 1);
  localparam int unsigned GIdxW = $clog2(MaxSubsetBits);

  typedef logic signed [LitW-1:0] lit_t;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_NUM_STATES  = 2'd0,
    CFG_NUM_SUBSETS = 2'd1,
    CFG_AUX_BASE    = 2'd2
  } bac_cfg_addr_e;

  typedef struct packed {
    logic capture;
    logic start_gs;
    logic start_pos;
    logic commit;
    logic rd_first;
    logic emit_pair;
    logic emit_marker;
    logic emit_aux;
  } bac_cmd_t;

  typedef struct packed {
    logic run_ok;
    logic div_done;
    logic out_free;
    logic ovf;
    logic w_zero;
    logic aux_zero;
    logic pair_last;
    logic aux_last;
  } bac_stat_t;

  // Number of address bits for a subset count: ceil(log2(nsub))
  function automatic logic [BitsW-1:0] subset_bits(input logic [NsubW-1:0] nsub);
    logic [BitsW-1:0] n;
    n = '0;
    for (int k = 0; k < int'(MaxSubsetBits); k++) begin
      if (int'(nsub) > (1 << k)) n = BitsW'(n + 1'b1);
    end
    return n;
  endfunction

endpackage

>>> src/bac_if.sv
interface bac_in_if;
  logic                       valid;
  logic                       ready;
  logic signed [bac_pkg::LitW-1:0] state_literal;

  modport source (output valid, output state_literal, input ready);
  modport sink   (input valid, input state_literal, output ready);
endinterface

interface bac_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [bac_pkg::LitW-1:0] first_literal;
  logic signed [bac_pkg::LitW-1:0] second_literal;
  logic                       last_of_run;
  logic                       group_overflow;

  modport source (output valid, output first_literal, output second_literal,
                  output last_of_run, output group_overflow, input ready);
  modport sink   (input valid, input first_literal, input second_literal,
                  input last_of_run, input group_overflow, output ready);
endinterface

interface bac_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bac_pkg::CfgAddrW-1:0]  addr;
  logic [bac_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> src/bac_ram.sv
module bac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bac_divider.sv
module bac_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bac_pkg::DivW-1:0] dividend_i,
  input  logic [bac_pkg::DivW-1:0] divisor_i,
  output logic                     done_o,
  output logic [bac_pkg::DivW-1:0] quotient_o,
  output logic [bac_pkg::DivW-1:0] remainder_o
);
  import bac_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q, rem_q, div_q;
  logic [DivW:0]   rem_sh, diff;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign diff   = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[DivW]) begin
        rem_q <= diff[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DivW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> src/bac_datapath.sv
module bac_datapath #(
  parameter int unsigned MAX_GROUP = bac_pkg::MaxGroup
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [bac_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bac_pkg::CfgDataW-1:0] cfg_data_i,
  input  bac_pkg::lit_t                state_literal_i,
  input  bac_pkg::bac_cmd_t            cmd_i,
  output bac_pkg::bac_stat_t           stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bac_pkg::lit_t                first_literal_o,
  output bac_pkg::lit_t                second_literal_o,
  output logic                         last_of_run_o,
  output logic                         group_overflow_o
);
  import bac_pkg::*;

  localparam int unsigned AW = $clog2(MAX_GROUP);

  logic [NsW-1:0]   ns_q;
  logic [NsubW-1:0] nsub_q;
  logic [AuxW-1:0]  aux_base_q;
  logic [NsW-1:0]   pos_q;
  logic [LitW-1:0]  cur_q;
  logic [AW-1:0]    i_q;
  logic [BitsW-1:0] j_q;

  logic [NsW-1:0]   ns_eff;
  logic [NsubW-1:0] nsub_eff;
  logic [BitsW-1:0] bits;
  logic             div_start, div_done;
  logic [DivW-1:0]  dividend, divisor, div_quo, div_rem;
  logic [LitW-1:0]  neg_cur, mem_rdata, aux_var, aux_lit, first_d;
  logic [MaxSubsetBits-1:0] grp;
  logic             ovf, emit_any, last_d;
  logic             out_valid_q, last_q, ovf_q;
  logic [LitW-1:0]  first_q, second_q;
  logic [AW-1:0]    raddr;

  // Clamp out-of-range register values
  assign ns_eff   = (ns_q > NsW'(MaxStates)) ? NsW'(MaxStates) : ns_q;
  assign nsub_eff = (nsub_q == '0) ? NsubW'(1) :
                    (nsub_q > NsubW'(MaxSubsets)) ? NsubW'(MaxSubsets) : nsub_q;
  assign bits     = subset_bits(nsub_eff);

  // Shared divider: first group size, then position / group size
  assign div_start = cmd_i.start_gs | cmd_i.start_pos;
  assign dividend  = cmd_i.start_gs ? DivW'(DivW'(ns_eff) + DivW'(nsub_eff) - DivW'(1))
                                    : DivW'(pos_q);
  assign divisor   = cmd_i.start_gs ? DivW'(nsub_eff) : div_quo;

  bac_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Quotient is the group, remainder the place in the group
  assign ovf = div_rem >= DivW'(MAX_GROUP);
  assign grp = div_quo[MaxSubsetBits-1:0];

  assign raddr = cmd_i.rd_first ? '0 : AW'(i_q + 1'b1);

  bac_ram #(
    .WIDTH (LitW),
    .DEPTH (MAX_GROUP)
  ) u_members (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit & ~ovf),
    .waddr_i (div_rem[AW-1:0]),
    .wdata_i (cur_q),
    .re_i    (cmd_i.rd_first | cmd_i.emit_pair),
    .raddr_i (raddr),
    .rdata_o (mem_rdata)
  );

  assign neg_cur = LitW'(0) - cur_q;
  assign aux_var = {1'b0, aux_base_q} + LitW'(j_q);
  assign aux_lit = grp[j_q[GIdxW-1:0]] ? (LitW'(0) - aux_var) : aux_var;

  always_comb begin
    first_d = aux_lit;
    last_d  = stat_o.aux_last;
    if (cmd_i.emit_pair) begin
      first_d = LitW'(0) - mem_rdata;
      last_d  = stat_o.pair_last & stat_o.aux_zero;
    end else if (cmd_i.emit_marker) begin
      first_d = '0;
      last_d  = stat_o.aux_zero;
    end
  end

  assign emit_any = cmd_i.emit_pair | cmd_i.emit_marker | cmd_i.emit_aux;

  always_comb begin
    stat_o.run_ok    = (ns_eff > NsW'(1)) && (pos_q < ns_eff);
    stat_o.div_done  = div_done;
    stat_o.out_free  = ~out_valid_q | out_ready_i;
    stat_o.ovf       = ovf;
    stat_o.w_zero    = (div_rem == '0);
    stat_o.aux_zero  = (bits == '0);
    stat_o.pair_last = (DivW'(i_q) + DivW'(1)) == div_rem;
    stat_o.aux_last  = BitsW'(j_q + 1'b1) == bits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q        <= '0;
      nsub_q      <= NsubW'(1);
      aux_base_q  <= AuxW'(1);
      pos_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (bac_cfg_addr_e'(cfg_addr_i))
          CFG_NUM_STATES:  ns_q       <= cfg_data_i[NsW-1:0];
          CFG_NUM_SUBSETS: nsub_q     <= cfg_data_i[NsubW-1:0];
          CFG_AUX_BASE:    aux_base_q <= cfg_data_i[AuxW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        pos_q <= NsW'(pos_q + 1'b1);
        i_q   <= '0;
        j_q   <= '0;
      end
      if (cmd_i.emit_pair) i_q <= AW'(i_q + 1'b1);
      if (cmd_i.emit_aux)  j_q <= BitsW'(j_q + 1'b1);
      if (emit_any)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) cur_q <= state_literal_i;
    if (emit_any) begin
      first_q  <= first_d;
      second_q <= neg_cur;
      last_q   <= last_d;
      ovf_q    <= cmd_i.emit_marker | (cmd_i.emit_aux & ovf);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign first_literal_o  = first_q;
  assign second_literal_o = second_q;
  assign last_of_run_o    = last_q;
  assign group_overflow_o = ovf_q;

endmodule

>>> src/bac_ctrl.sv
module bac_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bac_pkg::bac_stat_t stat_i,
  output bac_pkg::bac_cmd_t  cmd_o
);
  import bac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GS,
    ST_DIV_POS,
    ST_SETUP,
    ST_PAIR,
    ST_MARKER,
    ST_AUX
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.run_ok) begin
            cmd_o.start_gs = 1'b1;
            state_d        = ST_DIV_GS;
          end
        end
      end
      ST_DIV_GS: begin
        if (stat_i.div_done) begin
          cmd_o.start_pos = 1'b1;
          state_d         = ST_DIV_POS;
        end
      end
      ST_DIV_POS: begin
        if (stat_i.div_done) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.commit = 1'b1;
        priority if (stat_i.ovf) begin
          state_d = ST_MARKER;
        end else if (!stat_i.w_zero) begin
          cmd_o.rd_first = 1'b1;
          state_d        = ST_PAIR;
        end else if (!stat_i.aux_zero) begin
          state_d = ST_AUX;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAIR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_pair = 1'b1;
          if (stat_i.pair_last) state_d = stat_i.aux_zero ? ST_IDLE : ST_AUX;
        end
      end
      ST_MARKER: begin
        if (stat_i.out_free) begin
          cmd_o.emit_marker = 1'b1;
          state_d = stat_i.aux_zero ? ST_IDLE : ST_AUX;
        end
      end
      ST_AUX: begin
        if (stat_i.out_free) begin
          cmd_o.emit_aux = 1'b1;
          if (stat_i.aux_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/bimander_amo_clause_emitter.sv
// Sequence: a request that runs goes through two 14-step serial divisions (group size,
//   then group and place) and a setup state; then its clauses follow, one clause per cycle
//   without back-pressure. An absorbed request (too few states, past end) starts no work.
// Flow: a new request is taken only in the idle state, after all n clauses of the last one
//   (up to 37) are loaded; the shared serial divider and the one-clause output register set this.
// Reset: rst_ni clears the registers to their defaults and the state position.
module bimander_amo_clause_emitter #(
  parameter int unsigned MAX_GROUP = bac_pkg::MaxGroup
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bac_cfg_if.sink   cfg_i,
  bac_in_if.sink    in_i,
  bac_out_if.source out_o
);
  import bac_pkg::*;

  bac_cmd_t  cmd;
  bac_stat_t stat;
  logic      in_ready;

  // Configuration writes land at once; never stall them
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  // Sequencer: take a request, run the divisions, then walk the clauses
  bac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Registers, divider, member store and the output register
  bac_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_addr_i       (cfg_i.addr),
    .cfg_data_i       (cfg_i.data),
    .state_literal_i  (in_i.state_literal),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .first_literal_o  (out_o.first_literal),
    .second_literal_o (out_o.second_literal),
    .last_of_run_o    (out_o.last_of_run),
    .group_overflow_o (out_o.group_overflow)
  );

`ifndef SYNTHESIS
  // Never load a clause while the output register still holds one
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_pair || cmd.emit_marker || cmd.emit_aux) |-> stat.out_free)
    else $error("clause loaded into a full output register");

  // At most one clause source per cycle
  a_emit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.emit_pair, cmd.emit_marker, cmd.emit_aux}))
    else $error("two clause sources at once");

  // A request that starts work blocks the next one
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && stat.run_ok) |=> !in_i.ready)
    else $error("request taken while busy");

  // The divider never reports done right after a group-size division starts
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_gs |=> !stat.div_done)
    else $error("divider done right after start");
`endif

endmodule
